// File: design/psdt_pkg.sv
// Package for the power-switch debounce and tick generator.
// Types, register indexes and reset values shared by the design files that import it.
package psdt_pkg;

  typedef enum logic [1:0] {
    CFG_TICK_PRELOAD   = 2'd0,
    CFG_SWITCH_MODE    = 2'd1,
    CFG_DEBOUNCE_COUNT = 2'd2,
    CFG_HOLD_COUNT     = 2'd3
  } cfg_idx_t;

  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0] TickPreloadRst   = 8'd100;
  localparam logic       SwitchModeRst    = 1'b0;
  localparam logic [7:0] DebounceCountRst = 8'd50;
  localparam logic [7:0] HoldCountRst     = 8'd30;

  localparam logic MODE_LATCHING = 1'b0;
  localparam logic SUPPLY_OFF    = 1'b1;

  typedef struct packed {
    logic [7:0] tick_preload;
    logic       switch_mode;
    logic [7:0] debounce_count;
    logic [7:0] hold_count;
  } cfg_t;

  typedef struct packed {
    logic tick_level;
    logic power_off_n;
    logic half_period_end;
  } result_t;

endpackage

// File: design/psdt_if.sv
// Valid/ready channel interfaces for the input item and the result item.
// Stand-alone; no package dependency.
interface psdt_in_if;
  logic valid;
  logic ready;
  logic switch_released;

  modport source (output valid, output switch_released, input ready);
  modport sink   (input valid, input switch_released, output ready);
endinterface

interface psdt_out_if;
  logic valid;
  logic ready;
  logic tick_level;
  logic power_off_n;
  logic half_period_end;

  modport source (output valid, output tick_level, output power_off_n,
                  output half_period_end, input ready);
  modport sink   (input valid, input tick_level, input power_off_n,
                  input half_period_end, output ready);
endinterface

// File: design/psdt_cfg.sv
// Configuration register file: four registers behind a plain write port.
// Depends on psdt_pkg.
module psdt_cfg
  import psdt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                we,
  input  cfg_idx_t            idx,
  input  logic [CfgDataW-1:0] wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (idx)
        CFG_TICK_PRELOAD:   cfg_nxt.tick_preload   = wdata;
        CFG_SWITCH_MODE:    cfg_nxt.switch_mode    = wdata[0];
        CFG_DEBOUNCE_COUNT: cfg_nxt.debounce_count = wdata;
        CFG_HOLD_COUNT:     cfg_nxt.hold_count     = wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_preload   <= TickPreloadRst;
      cfg_r.switch_mode    <= SwitchModeRst;
      cfg_r.debounce_count <= DebounceCountRst;
      cfg_r.hold_count     <= HoldCountRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/psdt_in_stage.sv
// Input register: captures the switch sample of each accepted item.
// Depends on psdt_if.
module psdt_in_stage (
  input  logic        clk,
  input  logic        rst_n,
  psdt_in_if.sink     in_chan,
  input  logic        advance,
  output logic        s1_valid,
  output logic        s1_released
);

  logic valid_r, valid_nxt;
  logic released_r, released_nxt;
  logic take;

  assign in_chan.ready = !valid_r || advance;
  assign take = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt    = valid_r;
    released_nxt = released_r;
    if (take) begin
      valid_nxt    = 1'b1;
      released_nxt = in_chan.switch_released;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    released_r <= released_nxt;
  end

  assign s1_valid    = valid_r;
  assign s1_released = released_r;

endmodule

// File: design/psdt_step.sv
// Timer, tick and switch state with the per-item update logic.
// Depends on psdt_pkg.
module psdt_step
  import psdt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  logic    released,
  input  cfg_t    cfg,
  output result_t res
);

  logic [7:0] timer_r, timer_nxt;
  logic       tick_r, tick_nxt;
  logic       stored_r, stored_nxt;
  logic       pin_r, pin_nxt;
  logic [7:0] press_r, press_nxt;
  logic [7:0] hold_r, hold_nxt;

  logic [7:0] timer_inc;
  logic       wrapped;
  logic       acting;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  assign timer_inc = timer_r + 8'd1;
  assign wrapped   = (timer_inc == 8'd0);

  always_comb begin
    timer_nxt  = timer_inc;
    tick_nxt   = tick_r;
    stored_nxt = stored_r;
    pin_nxt    = pin_r;
    press_nxt  = press_r;
    hold_nxt   = hold_r;
    acting     = 1'b0;
    if (wrapped) begin
      timer_nxt = cfg.tick_preload;
      tick_nxt  = !tick_r;
      if (cfg.switch_mode == MODE_LATCHING) begin
        pin_nxt = released;
      end else if (!released) begin
        press_nxt = sat_inc(press_r);
      end
      acting = (press_nxt > cfg.debounce_count);
      if (acting) begin
        hold_nxt = sat_inc(hold_r);
        pin_nxt  = !stored_r;
      end
      // release after a long enough hold flips the stored power state
      if (released && acting && (hold_nxt > cfg.hold_count)) begin
        stored_nxt = !stored_r;
        press_nxt  = 8'd0;
        hold_nxt   = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r  <= TickPreloadRst;
      tick_r   <= 1'b0;
      stored_r <= SUPPLY_OFF;
      pin_r    <= SUPPLY_OFF;
      press_r  <= 8'd0;
      hold_r   <= 8'd0;
    end else if (fire) begin
      timer_r  <= timer_nxt;
      tick_r   <= tick_nxt;
      stored_r <= stored_nxt;
      pin_r    <= pin_nxt;
      press_r  <= press_nxt;
      hold_r   <= hold_nxt;
    end
  end

  assign res.tick_level      = tick_nxt;
  assign res.power_off_n     = pin_nxt;
  assign res.half_period_end = wrapped;

endmodule

// File: design/psdt_out_reg.sv
// Result register driving the output channel.
// Depends on psdt_pkg and psdt_if.
module psdt_out_reg
  import psdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     res,
  psdt_out_if.source  out_chan,
  output logic        advance
);

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign advance = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_chan.valid           = valid_r;
  assign out_chan.tick_level      = res_r.tick_level;
  assign out_chan.power_off_n     = res_r.power_off_n;
  assign out_chan.half_period_end = res_r.half_period_end;

endmodule

// File: design/power_switch_debounce_tick_gen.sv
// Power-switch debounce and tick generator, top level.
// Pipeline: the input register, then the result register, with the state update
// between them. Throughput: one item per cycle while the output is not stalled;
// the state update is a single 8-bit step.
// Reset (rst_n, sync, active low): timer = 100, tick 0, power off, counters 0,
// configuration back to its defaults, both pipeline registers empty.
module power_switch_debounce_tick_gen
  import psdt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  psdt_in_if.sink             in_chan,
  psdt_out_if.source          out_chan,
  input  logic                cfg_we,
  input  cfg_idx_t            cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t    cfg;
  result_t res;
  logic    s1_valid;
  logic    s1_released;
  logic    advance;
  logic    fire;

  assign fire = s1_valid && advance;

  psdt_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_idx),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  psdt_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .advance     (advance),
    .s1_valid    (s1_valid),
    .s1_released (s1_released)
  );

  psdt_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .released (s1_released),
    .cfg      (cfg),
    .res      (res)
  );

  psdt_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .res      (res),
    .out_chan (out_chan),
    .advance  (advance)
  );

endmodule

// File: bench/power_switch_debounce_tick_gen_test.sv
`timescale 1ns / 1ps
// Self-checking bench for power_switch_debounce_tick_gen: drives timer count items with
// random gaps and back-pressure, and predicts tick, supply pin and wrap flag per item.
// Depends on psdt_pkg (types, register indexes, reset values) and the psdt_if channels.
module power_switch_debounce_tick_gen_test;
  import psdt_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  psdt_in_if  in_chan ();
  psdt_out_if out_chan ();

  power_switch_debounce_tick_gen dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted block state and register copy
  cfg_t       pred_cfg;
  logic [7:0] pred_timer;
  logic       pred_tick;
  logic       pred_stored;
  logic       pred_pin;
  logic [7:0] pred_press;
  logic [7:0] pred_hold;

  result_t tick_pin_queue[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned long_hold_cycles = 0;
  bit steady = 1'b0;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // One timer count: wrap handling and switch logic, returns the expected outputs.
  function automatic result_t advance_timer_count(input logic released);
    result_t r;
    logic wrapped;
    wrapped = 1'b0;
    pred_timer = pred_timer + 8'd1;
    if (pred_timer == 8'd0) begin
      wrapped = 1'b1;
      pred_tick = ~pred_tick;
      pred_timer = pred_cfg.tick_preload;
      if (pred_cfg.switch_mode == MODE_LATCHING) begin
        pred_pin = released ? SUPPLY_OFF : ~SUPPLY_OFF;
      end else if (!released) begin
        pred_press = sat_inc(pred_press);
      end
      // runs in both modes; leftover press counts override the latching pin
      if (pred_press > pred_cfg.debounce_count) begin
        pred_hold = sat_inc(pred_hold);
        pred_pin = ~pred_stored;
      end
      if (released && pred_press > pred_cfg.debounce_count &&
          pred_hold > pred_cfg.hold_count) begin
        pred_stored = ~pred_stored;
        pred_press = 8'd0;
        pred_hold = 8'd0;
      end
    end
    r.tick_level = pred_tick;
    r.power_off_n = pred_pin;
    r.half_period_end = wrapped;
    return r;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_sample(input logic released);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.switch_released <= released;
    do @(posedge clk); while (!in_chan.ready);
    tick_pin_queue.push_back(advance_timer_count(released));
  endtask

  // A press of n_press items then a release, each with occasional bounce
  task automatic send_press_release(input int unsigned n_press, input int unsigned n_release);
    repeat (n_press) send_sample($urandom_range(0, 11) == 0);
    repeat (n_release) send_sample($urandom_range(0, 11) != 0);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (tick_pin_queue.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes all four registers once the pipeline is empty
  task automatic set_config(input logic [7:0] preload, input logic mode,
                            input logic [7:0] deb, input logic [7:0] hold);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_TICK_PRELOAD;
    cfg_wdata <= preload;
    @(posedge clk);
    cfg_idx <= CFG_SWITCH_MODE;
    cfg_wdata <= {{(CfgDataW-1){1'b0}}, mode};
    @(posedge clk);
    cfg_idx <= CFG_DEBOUNCE_COUNT;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_idx <= CFG_HOLD_COUNT;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred_cfg.tick_preload = preload;
    pred_cfg.switch_mode = mode;
    pred_cfg.debounce_count = deb;
    pred_cfg.hold_count = hold;
  endtask

  // Reset configuration: preload 100, so a wrap every 156 items
  task automatic test_reset_defaults();
    repeat (4) send_press_release($urandom_range(0, 40), $urandom_range(0, 40));
  endtask

  task automatic test_directed();
    set_config(8'd255, MODE_LATCHING, 8'd0, 8'd0);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b1);
    send_sample(1'b0);
    // momentary, zero thresholds: each press and release toggles power
    set_config(8'd255, ~MODE_LATCHING, 8'd0, 8'd0);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b1);
    // wrap every second item
    set_config(8'd254, ~MODE_LATCHING, 8'd1, 8'd0);
    repeat (4) send_sample(1'b0);
    repeat (2) send_sample(1'b1);
  endtask

  task automatic test_saturation();
    // the press count climbs to 255 before a release may toggle
    set_config(8'd255, ~MODE_LATCHING, 8'd254, 8'd0);
    repeat (256) send_sample(1'b0);
    repeat (2) send_sample(1'b1);
    // debounce of 255 is never exceeded; the press count stays at 255
    set_config(8'd255, ~MODE_LATCHING, 8'd255, 8'd0);
    repeat (258) send_sample(1'b0);
    repeat (2) send_sample(1'b1);
    // hold of 255 is never exceeded either
    set_config(8'd255, ~MODE_LATCHING, 8'd0, 8'd255);
    repeat (258) send_sample(1'b0);
    repeat (2) send_sample(1'b1);
    // release with thresholds dropped clears both counters
    set_config(8'd255, ~MODE_LATCHING, 8'd0, 8'd0);
    repeat (2) send_sample(1'b1);
  endtask

  task automatic test_momentary_presses();
    int unsigned deb;
    int unsigned hold;
    repeat (3) begin
      deb = $urandom_range(0, 6);
      hold = $urandom_range(0, 6);
      set_config($urandom_range(0, 1) ? 8'd255 : 8'd254, ~MODE_LATCHING,
                 8'(deb), 8'(hold));
      steady = ($urandom_range(0, 3) == 0);
      repeat (8) send_press_release($urandom_range(0, 2 * (deb + hold) + 10),
                                    $urandom_range(1, 6));
      steady = 1'b0;
    end
  endtask

  // Press count built in momentary mode still acts after the switch to latching
  task automatic test_mode_change();
    repeat (6) begin
      set_config(8'd255, ~MODE_LATCHING, 8'd3, 8'd2);
      send_press_release($urandom_range(0, 8), 0);
      set_config(8'd255, MODE_LATCHING, 8'd3, 8'd2);
      repeat ($urandom_range(4, 12)) send_sample(1'($urandom_range(0, 1)));
    end
  endtask

  // Preload writes take effect at the next reload; the running count is kept
  task automatic test_preload_sweep();
    set_config(8'd0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 2)),
               8'($urandom_range(0, 2)));
    repeat (7) send_press_release($urandom_range(0, 40), $urandom_range(0, 40));
    set_config(8'($urandom_range(128, 250)), 1'($urandom_range(0, 1)), 8'd1, 8'd1);
    repeat (3) send_press_release($urandom_range(0, 40), $urandom_range(0, 40));
    set_config(8'd255, 1'($urandom_range(0, 1)), 8'd2, 8'd3);
    repeat (6) send_press_release($urandom_range(0, 12), $urandom_range(0, 6));
  endtask

  // Receiver stalls for a long stretch while items keep coming
  task automatic test_backpressure();
    set_config(8'd254, ~MODE_LATCHING, 8'd2, 8'd1);
    steady = 1'b1;
    long_hold_cycles = 300;
    repeat (12) send_press_release($urandom_range(0, 12), $urandom_range(1, 4));
    steady = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_cycles != 0) begin
        stall_left = long_hold_cycles;
        long_hold_cycles = 0;
      end
      if (stall_left != 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (tick_pin_queue.size() == 0) begin
        $error("result item with nothing awaited");
        mismatches++;
      end else begin
        exp_r = tick_pin_queue.pop_front();
        if (out_chan.tick_level !== exp_r.tick_level) begin
          $error("tick_level: expected %0b, got %0b", exp_r.tick_level, out_chan.tick_level);
          mismatches++;
        end
        if (out_chan.power_off_n !== exp_r.power_off_n) begin
          $error("power_off_n: expected %0b, got %0b", exp_r.power_off_n,
                 out_chan.power_off_n);
          mismatches++;
        end
        if (out_chan.half_period_end !== exp_r.half_period_end) begin
          $error("half_period_end: expected %0b, got %0b", exp_r.half_period_end,
                 out_chan.half_period_end);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.switch_released <= 1'b1;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_TICK_PRELOAD;
    cfg_wdata <= '0;
    pred_cfg.tick_preload = TickPreloadRst;
    pred_cfg.switch_mode = SwitchModeRst;
    pred_cfg.debounce_count = DebounceCountRst;
    pred_cfg.hold_count = HoldCountRst;
    pred_timer = TickPreloadRst;
    pred_tick = 1'b0;
    pred_stored = SUPPLY_OFF;
    pred_pin = SUPPLY_OFF;
    pred_press = 8'd0;
    pred_hold = 8'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    test_saturation();
    test_momentary_presses();
    test_mode_change();
    test_preload_sweep();
    test_backpressure();
    drain();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
design/psdt_pkg.sv
design/psdt_if.sv
design/psdt_cfg.sv
design/psdt_in_stage.sv
design/psdt_step.sv
design/psdt_out_reg.sv
design/power_switch_debounce_tick_gen.sv
bench/power_switch_debounce_tick_gen_test.sv
